// ===== src/noekeon_block_encrypt_core_macros.svh =====
`ifndef NOEKEON_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define NOEKEON_BLOCK_ENCRYPT_CORE_MACROS_SVH

// same-cycle implication, disabled while rst_sig is high
`define NKBE_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("nkbe same-cycle check failed");

// next-cycle implication, disabled while rst_sig is high
`define NKBE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("nkbe next-cycle check failed");

`endif

// ===== src/nkbe_pkg.sv =====
package nkbe_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RC_IDX_W  = 5;
  localparam int unsigned KEY_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0][WORD_W-1:0] state_t;
  typedef logic [7:0] rc_t;
  typedef logic [RC_IDX_W-1:0] rc_idx_t;

  typedef enum logic [KEY_IDX_W-1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } key_idx_t;

  function automatic rc_t round_const(input rc_idx_t idx);
    rc_t rc;
    case (idx)
      5'd0:    rc = 8'h80;
      5'd1:    rc = 8'h1b;
      5'd2:    rc = 8'h36;
      5'd3:    rc = 8'h6c;
      5'd4:    rc = 8'hd8;
      5'd5:    rc = 8'hab;
      5'd6:    rc = 8'h4d;
      5'd7:    rc = 8'h9a;
      5'd8:    rc = 8'h2f;
      5'd9:    rc = 8'h5e;
      5'd10:   rc = 8'hbc;
      5'd11:   rc = 8'h63;
      5'd12:   rc = 8'hc6;
      5'd13:   rc = 8'h97;
      5'd14:   rc = 8'h35;
      5'd15:   rc = 8'h6a;
      5'd16:   rc = 8'hd4;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic state_t theta(input state_t s, input state_t k);
    state_t a;
    word_t t;
    a = s;
    t = a[0] ^ a[2];
    t = t ^ rotl(t, 8) ^ rotl(t, 24);
    a[1] = a[1] ^ t;
    a[3] = a[3] ^ t;
    a = a ^ k;
    t = a[1] ^ a[3];
    t = t ^ rotl(t, 8) ^ rotl(t, 24);
    a[0] = a[0] ^ t;
    a[2] = a[2] ^ t;
    return a;
  endfunction

  function automatic state_t gamma(input state_t s);
    state_t a;
    word_t sw;
    a = s;
    a[1] = a[1] ^ ~(a[3] | a[2]);
    a[0] = a[0] ^ (a[2] & a[1]);
    sw   = a[0];
    a[0] = a[3];
    a[3] = sw;
    a[2] = a[2] ^ a[0] ^ a[1] ^ a[3];
    a[1] = a[1] ^ ~(a[3] | a[2]);
    a[0] = a[0] ^ (a[2] & a[1]);
    return a;
  endfunction

  function automatic state_t add_rc(input state_t s, input rc_t rc);
    state_t a;
    a = s;
    a[0] = a[0] ^ {{(WORD_W-8){1'b0}}, rc};
    return a;
  endfunction

  function automatic state_t full_round(input state_t s, input state_t k, input rc_t rc);
    state_t a;
    a = theta(add_rc(s, rc), k);
    a[1] = rotl(a[1], 1);
    a[2] = rotl(a[2], 5);
    a[3] = rotl(a[3], 2);
    a = gamma(a);
    a[1] = rotl(a[1], 31);
    a[2] = rotl(a[2], 27);
    a[3] = rotl(a[3], 30);
    return a;
  endfunction

endpackage

// ===== src/nkbe_round.sv =====
module nkbe_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  nkbe_pkg::state_t in_state,
  input  nkbe_pkg::state_t key,
  input  nkbe_pkg::rc_t   rc,
  output logic            out_valid,
  output nkbe_pkg::state_t out_state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= nkbe_pkg::full_round(in_state, key, rc);
  end

endmodule

// ===== src/nkbe_out.sv =====
module nkbe_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  nkbe_pkg::state_t in_state,
  input  nkbe_pkg::state_t key,
  input  nkbe_pkg::rc_t    rc,
  output logic             out_valid,
  output nkbe_pkg::state_t out_state
);

  // output step: constant and theta only
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= nkbe_pkg::theta(nkbe_pkg::add_rc(in_state, rc), key);
  end

endmodule

// ===== src/noekeon_block_encrypt_core.sv =====
// channel   direction  handshake          payload
// command   in         start, busy        plain_word0..plain_word3
// result    out        done (strobe)      cipher_word0..cipher_word3
// key       in         wr_en, wr_index    wr_data (key_word0..key_word3)
//
// one block enters per cycle outside reset, even while earlier blocks are still in flight
// the pipeline has one register stage per round plus one for the output step
// busy follows rst, so nothing is taken during reset
// rst clears the key registers and every stage valid bit; blocks in flight are dropped
// done lasts one cycle and cannot be held off by the receiver
module noekeon_block_encrypt_core #(
  parameter int unsigned ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] plain_word0,
  input  logic [31:0] plain_word1,
  input  logic [31:0] plain_word2,
  input  logic [31:0] plain_word3,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        done,
  output logic [31:0] cipher_word0,
  output logic [31:0] cipher_word1,
  output logic [31:0] cipher_word2,
  output logic [31:0] cipher_word3
);

  nkbe_pkg::state_t key;
  logic             stage_valid [ROUNDS+1];
  nkbe_pkg::state_t stage_state [ROUNDS+1];
  logic             final_valid;
  nkbe_pkg::state_t final_state;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      case (nkbe_pkg::key_idx_t'(wr_index))
        nkbe_pkg::KEY_WORD0: key[0] <= wr_data;
        nkbe_pkg::KEY_WORD1: key[1] <= wr_data;
        nkbe_pkg::KEY_WORD2: key[2] <= wr_data;
        nkbe_pkg::KEY_WORD3: key[3] <= wr_data;
        default: ;
      endcase
    end
  end

  assign stage_valid[0] = start && !busy;
  assign stage_state[0] = {plain_word3, plain_word2, plain_word1, plain_word0};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    nkbe_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_state  (stage_state[i]),
      .key       (key),
      .rc        (nkbe_pkg::round_const(nkbe_pkg::rc_idx_t'(i))),
      .out_valid (stage_valid[i+1]),
      .out_state (stage_state[i+1])
    );
  end

  nkbe_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[ROUNDS]),
    .in_state  (stage_state[ROUNDS]),
    .key       (key),
    .rc        (nkbe_pkg::round_const(nkbe_pkg::rc_idx_t'(ROUNDS))),
    .out_valid (final_valid),
    .out_state (final_state)
  );

  assign done         = final_valid;
  assign cipher_word0 = final_state[0];
  assign cipher_word1 = final_state[1];
  assign cipher_word2 = final_state[2];
  assign cipher_word3 = final_state[3];

endmodule

// ===== src/nkbe_chk.sv =====
`include "noekeon_block_encrypt_core_macros.svh"

module nkbe_chk #(
  parameter int unsigned ROUNDS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] plain_word0,
  input logic [31:0] plain_word1,
  input logic [31:0] plain_word2,
  input logic [31:0] plain_word3,
  input logic        wr_en,
  input logic [1:0]  wr_index,
  input logic [31:0] wr_data,
  input logic        done,
  input logic [31:0] cipher_word0,
  input logic [31:0] cipher_word1,
  input logic [31:0] cipher_word2,
  input logic [31:0] cipher_word3
);

  localparam int unsigned LATENCY = ROUNDS + 1;

  // every result traces back to an earlier accepted transaction
  `NKBE_ASSERT_NOW(a_done_has_start, clk, rst, done, $past(start && !busy, LATENCY))

  // reset flushes the pipeline
  `NKBE_ASSERT_NEXT(a_reset_flush, clk, 1'b0, rst, !done)

  // commands are taken every cycle outside reset
  `NKBE_ASSERT_NOW(a_never_busy, clk, 1'b0, !rst, !busy)

endmodule

bind noekeon_block_encrypt_core nkbe_chk #(.ROUNDS(ROUNDS)) u_nkbe_chk (.*);
